FILE: hw/rtl/sv39_page_table_mapper_macros.svh
// assertion macros shared by the mapper rtl
`ifndef SV39_PAGE_TABLE_MAPPER_MACROS_SVH
`define SV39_PAGE_TABLE_MAPPER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SV39PTM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sv39ptm: same-cycle check failed");

// next-cycle implication, disabled during reset
`define SV39PTM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sv39ptm: next-cycle check failed");

`endif

FILE: hw/rtl/sv39ptm_pkg.sv
package sv39ptm_pkg;

  // pool geometry
  localparam int POOL_PAGES = 16;
  localparam int VPN_W      = 9;
  localparam int ENTRIES    = 512;
  localparam int PAGE_W     = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int CNT_W      = $clog2(POOL_PAGES + 1);
  localparam int ADDR_W     = PAGE_W + VPN_W;
  localparam int DEPTH      = POOL_PAGES * ENTRIES;

  // field widths
  localparam int PPN_W  = 44;
  localparam int VA_W   = 39;
  localparam int PA_W   = 56;
  localparam int PERM_W = 8;
  localparam int PTE_W  = 64;
  localparam int USE_W  = 5;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  // which vpn slice addresses the table
  typedef enum logic [1:0] {
    VSEL_2 = 2'd0,
    VSEL_1 = 2'd1,
    VSEL_0 = 2'd2
  } vsel_t;

  // write data source
  typedef enum logic [1:0] {
    WSEL_ZERO = 2'd0,
    WSEL_PTR  = 2'd1,
    WSEL_LEAF = 2'd2
  } wsel_t;

  // controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    clr_step;
    logic    wr_en;
    wsel_t   wsel;
    vsel_t   vsel;
    logic    follow;
    logic    alloc;
    logic    st_load;
    status_t st_code;
    logic    load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic pte_v;
    logic outside;
    logic full;
    logic out_busy;
  } sts_t;

endpackage

FILE: hw/rtl/sv39ptm_if.sv
// request channel: one mapping to install
interface sv39ptm_req_if;
  import sv39ptm_pkg::*;
  logic              valid;
  logic              ready;
  logic [VA_W-1:0]   virt_addr;
  logic [PA_W-1:0]   phys_addr;
  logic [PERM_W-1:0] perm_bits;
  modport source (output valid, output virt_addr, output phys_addr, output perm_bits,
                  input ready);
  modport sink (input valid, input virt_addr, input phys_addr, input perm_bits,
                output ready);
endinterface

// response channel: one result per request
interface sv39ptm_rsp_if;
  import sv39ptm_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             offset_mismatch;
  logic [PTE_W-1:0] leaf_entry;
  logic [USE_W-1:0] pages_in_use;
  modport source (output valid, output status, output offset_mismatch, output leaf_entry,
                  output pages_in_use, input ready);
  modport sink (input valid, input status, input offset_mismatch, input leaf_entry,
                input pages_in_use, output ready);
endinterface

// configuration write channel: pool base ppn
interface sv39ptm_cfg_if;
  import sv39ptm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PPN_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/sv39_page_table_mapper.sv
// Sv39 page-table mapper: each request on req installs one 4 KiB mapping by walking
// three table levels held in a pool of 16 table pages (pool page 0 is the root, page n
// sits at physical page pool_base_ppn + n), allocating pointer pages as needed and
// overwriting the leaf; each request yields one response on rsp with status, offset
// mismatch flag, leaf entry and pages in use. After reset the table store is swept to
// zero, one entry per cycle over all 8192 entries, while req.ready stays low; cfg writes
// are taken at any time but belong only to idle periods. A mapping is a walk of dependent
// accesses to one table memory with a registered read: the root and level-1 entries each
// get a read state and an evaluate/write state, the leaf gets a write state, and a done
// state loads the response register, waiting while the last response is untaken, then
// returns to idle for the next request; an early failure jumps from evaluate to done.
module sv39_page_table_mapper (
  input  logic          clk,
  input  logic          rst,
  sv39ptm_cfg_if.sink   cfg,
  sv39ptm_req_if.sink   req,
  sv39ptm_rsp_if.source rsp
);
  import sv39ptm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // config is always taken
  assign cfg.ready = 1'b1;

  // walk sequencer
  sv39ptm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table store, allocator and result register
  sv39ptm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg.valid),
    .cfg_data        (cfg.data),
    .virt_addr       (req.virt_addr),
    .phys_addr       (req.phys_addr),
    .perm_bits       (req.perm_bits),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .status          (rsp.status),
    .offset_mismatch (rsp.offset_mismatch),
    .leaf_entry      (rsp.leaf_entry),
    .pages_in_use    (rsp.pages_in_use)
  );

endmodule

FILE: hw/rtl/sv39ptm_dp.sv
`include "sv39_page_table_mapper_macros.svh"

module sv39ptm_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  sv39ptm_pkg::cmd_t                   cmd,
  output sv39ptm_pkg::sts_t                   sts,
  input  logic                                cfg_we,
  input  logic [sv39ptm_pkg::PPN_W-1:0]       cfg_data,
  input  logic [sv39ptm_pkg::VA_W-1:0]        virt_addr,
  input  logic [sv39ptm_pkg::PA_W-1:0]        phys_addr,
  input  logic [sv39ptm_pkg::PERM_W-1:0]      perm_bits,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sv39ptm_pkg::status_t                status,
  output logic                                offset_mismatch,
  output logic [sv39ptm_pkg::PTE_W-1:0]       leaf_entry,
  output logic [sv39ptm_pkg::USE_W-1:0]       pages_in_use
);
  import sv39ptm_pkg::*;

  logic [PPN_W-1:0]  base;
  logic [VA_W-1:0]   va;
  logic [PA_W-1:0]   pa;
  logic [PERM_W-1:0] perm;
  logic [PAGE_W-1:0] cur_page;
  logic [CNT_W-1:0]  next_free;
  status_t           st;
  logic [ADDR_W-1:0] clr_addr;
  logic [PTE_W-1:0]  mem [DEPTH];
  logic [PTE_W-1:0]  rdata;

  logic [VPN_W-1:0]  vpn;
  logic [ADDR_W-1:0] addr;
  logic [PPN_W-1:0]  diff;
  logic [PPN_W-1:0]  alloc_ppn;
  logic [PTE_W-1:0]  leaf;
  logic [PTE_W-1:0]  ptr;
  logic [PTE_W-1:0]  wdata;

  // base register
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (cfg_we) begin
      base <= cfg_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      va   <= virt_addr;
      pa   <= phys_addr;
      perm <= perm_bits;
    end
  end

  // vpn slice for the current level
  always_comb begin
    case (cmd.vsel)
      VSEL_2:  vpn = va[38:30];
      VSEL_1:  vpn = va[29:21];
      VSEL_0:  vpn = va[20:12];
      default: vpn = va[38:30];
    endcase
  end

  assign addr = cmd.clr_step ? clr_addr : {cur_page, vpn};

  // entry decode and pointer arithmetic
  assign diff      = rdata[53:10] - base;
  assign alloc_ppn = base + PPN_W'(next_free);
  assign leaf      = {10'b0, pa[55:12], 2'b0, perm};
  assign ptr       = {10'b0, alloc_ppn, 9'b0, 1'b1};

  always_comb begin
    case (cmd.wsel)
      WSEL_ZERO: wdata = '0;
      WSEL_PTR:  wdata = ptr;
      WSEL_LEAF: wdata = leaf;
      default:   wdata = '0;
    endcase
  end

  // table store, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  // clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // walk position
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_page <= '0;
    end else if (cmd.follow) begin
      cur_page <= diff[PAGE_W-1:0];
    end else if (cmd.alloc) begin
      cur_page <= next_free[PAGE_W-1:0];
    end
  end

  // page allocator
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= CNT_W'(1);
    end else if (cmd.alloc) begin
      next_free <= next_free + CNT_W'(1);
    end
  end

  // item status
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      st <= ST_OK;
    end else if (cmd.st_load) begin
      st <= cmd.st_code;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status          <= st;
      offset_mismatch <= (va[11:0] != pa[11:0]);
      leaf_entry      <= (st == ST_OK) ? leaf : '0;
      pages_in_use    <= USE_W'(next_free);
    end
  end

  // status to controller
  assign sts.clr_last = (clr_addr == ADDR_W'(DEPTH - 1));
  assign sts.pte_v    = rdata[0];
  assign sts.outside  = (diff >= PPN_W'(POOL_PAGES));
  assign sts.full     = (next_free == CNT_W'(POOL_PAGES));
  assign sts.out_busy = out_valid && !out_ready;

  `SV39PTM_ASSERT_IMP(a_free_range, clk, rst, 1'b1,
    next_free >= CNT_W'(1) && next_free <= CNT_W'(POOL_PAGES))
  `SV39PTM_ASSERT_IMP(a_fail_zero_leaf, clk, rst, out_valid && status != ST_OK,
    leaf_entry == '0)
  `SV39PTM_ASSERT_NXT(a_alloc_count, clk, rst, cmd.alloc,
    next_free == $past(next_free) + CNT_W'(1))

endmodule

FILE: hw/rtl/sv39ptm_ctrl.sv
`include "sv39_page_table_mapper_macros.svh"

module sv39ptm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sv39ptm_pkg::sts_t sts,
  output sv39ptm_pkg::cmd_t cmd
);
  import sv39ptm_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RD2   = 8'b0000_0100,
    S_EV2   = 8'b0000_1000,
    S_RD1   = 8'b0001_0000,
    S_EV1   = 8'b0010_0000,
    S_LEAF  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t st;
  state_t st_next;
  state_t lvl_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLEAR;
    end else begin
      st <= st_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd      = '0;
    st_next  = st;
    in_ready = 1'b0;
    lvl_next = S_RD1;
    case (st)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.wr_en    = 1'b1;
        cmd.wsel     = WSEL_ZERO;
        if (sts.clr_last) begin
          st_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          st_next     = S_RD2;
        end
      end
      S_RD2: begin
        cmd.vsel = VSEL_2;
        st_next  = S_EV2;
      end
      S_RD1: begin
        cmd.vsel = VSEL_1;
        st_next  = S_EV1;
      end
      S_EV2, S_EV1: begin
        cmd.vsel = (st == S_EV2) ? VSEL_2 : VSEL_1;
        lvl_next = (st == S_EV2) ? S_RD1 : S_LEAF;
        if (sts.pte_v) begin
          if (sts.outside) begin
            cmd.st_load = 1'b1;
            cmd.st_code = ST_OUTSIDE;
            st_next     = S_DONE;
          end else begin
            cmd.follow = 1'b1;
            st_next    = lvl_next;
          end
        end else if (sts.full) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_FULL;
          st_next     = S_DONE;
        end else begin
          cmd.wr_en = 1'b1;
          cmd.wsel  = WSEL_PTR;
          cmd.alloc = 1'b1;
          st_next   = lvl_next;
        end
      end
      S_LEAF: begin
        cmd.vsel  = VSEL_0;
        cmd.wr_en = 1'b1;
        cmd.wsel  = WSEL_LEAF;
        st_next   = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          st_next      = S_IDLE;
        end
      end
      default: begin
        st_next = S_CLEAR;
      end
    endcase
  end

  `SV39PTM_ASSERT_IMP(a_alloc_room, clk, rst, cmd.alloc, !sts.full)
  `SV39PTM_ASSERT_IMP(a_out_free, clk, rst, cmd.load_out, !sts.out_busy)
  `SV39PTM_ASSERT_NXT(a_accept_walk, clk, rst, in_valid && in_ready, st == S_RD2)

endmodule

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sv39ptm_pkg::*;

  // one mapping request and the response it should produce
  typedef struct packed {
    logic [VA_W-1:0]   va;
    logic [PA_W-1:0]   pa;
    logic [PERM_W-1:0] perm;
  } map_item_t;

  typedef struct packed {
    status_t          status;
    logic             offset_mismatch;
    logic [PTE_W-1:0] leaf_entry;
    logic [USE_W-1:0] pages_in_use;
  } map_result_t;

  localparam logic [PPN_W-1:0] BASE_MAX = '1;
  // covers the table sweep after reset plus the longest legal stalls, several times over
  localparam int STALL_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sv39ptm_cfg_if cfg_ch ();
  sv39ptm_req_if req_ch ();
  sv39ptm_rsp_if rsp_ch ();

  sv39_page_table_mapper dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  // mirror of the table pool, allocator and base register
  logic [PTE_W-1:0] table_mirror [DEPTH];
  logic [USE_W-1:0] mirror_free;
  logic [PPN_W-1:0] mirror_base;

  // stimulus and expectation stores
  map_item_t        pending_maps[$];
  map_result_t      expected_results[$];
  logic [PPN_W-1:0] pending_bases[$];
  logic [17:0]      good_paths[$];

  bit       req_took;
  bit       cfg_took;
  bit       allow_idle;
  int       req_gap;
  int       rsp_gap;
  int       mismatches;
  int       checked;
  int       base_writes;
  int       n_mapped;
  int       n_full;
  int       n_outside;
  int       n_offset;
  int       stall_cycles;

  // pool page index named by a pointer entry under the current base
  function automatic logic [PPN_W-1:0] pool_offset(input logic [PTE_W-1:0] pte);
    return pte[53:10] - mirror_base;
  endfunction

  // follow the entry at one level, or allocate the next pool page behind it
  function automatic status_t descend(input int unsigned page, input logic [VPN_W-1:0] vpn,
                                      output int unsigned nxt);
    int unsigned      slot;
    logic [PTE_W-1:0] pte;
    logic [PPN_W-1:0] ppn;
    logic [PPN_W-1:0] off;
    nxt = 0;
    slot = page * ENTRIES + vpn;
    pte = table_mirror[slot];
    if (pte[0]) begin
      off = pool_offset(pte);
      if (off >= PPN_W'(POOL_PAGES)) return ST_OUTSIDE;
      nxt = 32'(off[PAGE_W-1:0]);
      return ST_OK;
    end
    if (mirror_free >= POOL_PAGES) return ST_FULL;
    ppn = mirror_base + PPN_W'(mirror_free);
    table_mirror[slot] = {10'd0, ppn, 9'd0, 1'b1};
    nxt = 32'(mirror_free);
    mirror_free = mirror_free + 1'b1;
    return ST_OK;
  endfunction

  // full three-level walk and leaf write for one request
  function automatic map_result_t predict_mapping(input map_item_t it);
    map_result_t r;
    int unsigned l1;
    int unsigned l0;
    status_t     st;
    st = descend(0, it.va[38:30], l1);
    if (st == ST_OK) st = descend(l1, it.va[29:21], l0);
    r.leaf_entry = '0;
    if (st == ST_OK) begin
      r.leaf_entry = {10'd0, it.pa[55:12], 10'd0} + PTE_W'(it.perm);
      table_mirror[l0 * ENTRIES + it.va[20:12]] = r.leaf_entry;
      if (good_paths.size() >= 64) void'(good_paths.pop_front());
      good_paths.push_back(it.va[38:21]);
    end
    r.status = st;
    r.offset_mismatch = (it.va[11:0] != it.pa[11:0]);
    r.pages_in_use = mirror_free;
    return r;
  endfunction

  // root slot that is still empty, starting from a random one
  function automatic logic [VPN_W-1:0] free_root_slot();
    logic [VPN_W-1:0] v;
    v = VPN_W'($urandom);
    for (int k = 0; k < ENTRIES; k++) begin
      if (!table_mirror[v][0]) return v;
      v = v + 1'b1;
    end
    return v;
  endfunction

  // a vpn2/vpn1 pair whose walk needs exactly one new page
  function automatic logic find_single_alloc(output logic [17:0] path);
    logic [PPN_W-1:0] off;
    path = '0;
    for (int v2 = 0; v2 < ENTRIES; v2++) begin
      if (table_mirror[v2][0]) begin
        off = pool_offset(table_mirror[v2]);
        if (off < POOL_PAGES) begin
          for (int v1 = 0; v1 < ENTRIES; v1++) begin
            if (!table_mirror[off * ENTRIES + v1][0]) begin
              path = {v2[8:0], v1[8:0]};
              return 1'b1;
            end
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [VA_W-1:0] mk_va(input int v2, input int v1, input int v0,
                                            input int off);
    return {v2[8:0], v1[8:0], v0[8:0], off[11:0]};
  endfunction

  function automatic logic [PA_W-1:0] mk_pa(input logic [PPN_W-1:0] ppn, input logic [11:0] off);
    return {ppn, off};
  endfunction

  // random request, mostly along walks that already succeeded
  function automatic map_item_t random_map();
    map_item_t it;
    it.va = VA_W'({$urandom, $urandom});
    it.pa = PA_W'({$urandom, $urandom});
    it.perm = PERM_W'($urandom);
    if (good_paths.size() != 0 && $urandom_range(0, 3) != 0)
      it.va[38:21] = good_paths[$urandom_range(0, good_paths.size() - 1)];
    if ($urandom_range(0, 3) == 0) it.pa[11:0] = it.va[11:0];
    return it;
  endfunction

  task automatic queue_map(input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
                           input logic [PERM_W-1:0] perm);
    map_item_t it;
    it.va = va;
    it.pa = pa;
    it.perm = perm;
    pending_maps.push_back(it);
  endtask

  // wait until every queued mapping has been answered
  task automatic settle();
    while (pending_maps.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_base(input logic [PPN_W-1:0] b);
    settle();
    pending_bases.push_back(b);
    while (pending_bases.size() != 0) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!(req_ch.valid && !req_took)) begin
      if (req_gap != 0) begin
        req_gap = req_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_maps.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 7) == 0) begin
        req_gap = $urandom_range(0, 13);
        req_ch.valid <= 1'b0;
      end else begin
        req_ch.valid     <= 1'b1;
        req_ch.virt_addr <= pending_maps[0].va;
        req_ch.phys_addr <= pending_maps[0].pa;
        req_ch.perm_bits <= pending_maps[0].perm;
      end
    end
  end

  // response ready with random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_gap != 0) begin
      rsp_gap = rsp_gap - 1;
      rsp_ch.ready <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 7) == 0) begin
      rsp_gap = $urandom_range(0, 13);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // base register writes
  always @(negedge clk) begin
    if (rst) begin
      cfg_ch.valid <= 1'b0;
    end else if (!(cfg_ch.valid && !cfg_took)) begin
      if (pending_bases.size() != 0) begin
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= pending_bases[0];
      end else begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: check responses, then predict newly accepted requests
  always @(posedge clk) begin : monitor
    map_result_t want;
    if (!rst) begin
      // response transfer
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected response: status %0d mism %0b leaf %h used %0d",
                     rsp_ch.status, rsp_ch.offset_mismatch, rsp_ch.leaf_entry,
                     rsp_ch.pages_in_use);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.status != want.status || rsp_ch.offset_mismatch != want.offset_mismatch ||
              rsp_ch.leaf_entry != want.leaf_entry ||
              rsp_ch.pages_in_use != want.pages_in_use) begin
            if (mismatches < 10)
              $display({"mismatch on response %0d: want status %0d mism %0b leaf %h ",
                        "used %0d, got status %0d mism %0b leaf %h used %0d"},
                       checked, want.status, want.offset_mismatch, want.leaf_entry,
                       want.pages_in_use, rsp_ch.status, rsp_ch.offset_mismatch,
                       rsp_ch.leaf_entry, rsp_ch.pages_in_use);
            mismatches++;
          end
          case (want.status)
            ST_OK:      n_mapped++;
            ST_FULL:    n_full++;
            ST_OUTSIDE: n_outside++;
            default:    ;
          endcase
          if (want.offset_mismatch) n_offset++;
          checked++;
        end
      end
      // request transfer
      req_took = req_ch.valid && req_ch.ready;
      if (req_took) begin
        expected_results.push_back(predict_mapping({req_ch.virt_addr, req_ch.phys_addr,
                                                    req_ch.perm_bits}));
        void'(pending_maps.pop_front());
      end
      // base register transfer
      cfg_took = cfg_ch.valid && cfg_ch.ready;
      if (cfg_took) begin
        mirror_base = cfg_ch.data;
        void'(pending_bases.pop_front());
        base_writes++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [17:0]      path;
    logic [VA_W-1:0]  va;
    logic [PPN_W-1:0] phase_bases [7];
    req_ch.valid = 1'b0;
    req_ch.virt_addr = '0;
    req_ch.phys_addr = '0;
    req_ch.perm_bits = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst = 1'b1;
    allow_idle = 1'b1;
    req_gap = 0;
    rsp_gap = 0;
    stall_cycles = 0;
    for (int i = 0; i < DEPTH; i++) table_mirror[i] = '0;
    mirror_free = USE_W'(1);
    mirror_base = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // base at the top of the range: allocated page numbers wrap
    write_base(BASE_MAX);
    queue_map(mk_va(0, 0, 0, 0), '0, 8'h00);
    queue_map('1, '1, 8'hFF);
    queue_map(mk_va(0, 0, 5, 12'h123), mk_pa(44'd3, 12'h456), 8'h0F);
    queue_map(mk_va(0, 0, 0, 0), mk_pa(44'h0_000A_BCDE, 12'h000), 8'h01);
    queue_map(mk_va(0, 0, 9, 0), mk_pa(BASE_MAX, 12'hFFF), 8'hCF);
    queue_map(mk_va(511, 511, 0, 12'hFFF), mk_pa(44'h555_5555_5555, 12'h000), 8'h80);

    // shifted base: old pointers land on pages not yet allocated
    write_base(BASE_MAX - 5);
    queue_map(mk_va(0, 3, 1, 0), mk_pa(44'h123, 12'h000), 8'h03);
    queue_map(mk_va(511, 2, 4, 0), mk_pa(44'h0_F00D_0000, 12'h000), 8'h07);
    queue_map(mk_va(0, 3, 2, 1), mk_pa(44'hAAA_AAAA_AAAA, 12'h001), 8'h55);

    // far base: existing pointers fall outside the pool
    write_base(44'h800_0000_0000);
    queue_map(mk_va(0, 0, 0, 0), mk_pa(44'd1, 12'h000), 8'h01);
    queue_map(mk_va(511, 0, 0, 0), mk_pa(44'd2, 12'h000), 8'h01);
    queue_map(mk_va(100, 0, 0, 0), mk_pa(44'd4, 12'h000), 8'h0B);

    // zero base: leaves with V set get followed as pointers
    write_base('0);
    queue_map(mk_va(511, 5, 6, 0), mk_pa(44'd9, 12'h000), 8'h0F);
    queue_map(mk_va(511, 9, 0, 0), mk_pa(44'd7, 12'h000), 8'h01);
    queue_map(mk_va(0, 0, 0, 0), mk_pa(44'd5, 12'h000), 8'h01);
    settle();

    // drain the pool so the last walk runs dry at level 1 after a root pointer
    for (int k = 0; k < 24 && mirror_free < POOL_PAGES; k++) begin
      va = VA_W'({$urandom, $urandom});
      if ((POOL_PAGES - mirror_free) % 2 == 0 && find_single_alloc(path))
        va[38:21] = path;
      else
        va[38:30] = free_root_slot();
      queue_map(va, PA_W'({$urandom, $urandom}), PERM_W'($urandom));
      settle();
    end
    va = VA_W'({$urandom, $urandom});
    va[38:30] = free_root_slot();
    queue_map(va, PA_W'({$urandom, $urandom}), PERM_W'($urandom));

    // random phases under several base settings, the last one without idling
    phase_bases[0] = BASE_MAX;
    phase_bases[1] = BASE_MAX - 3;
    phase_bases[2] = '0;
    phase_bases[3] = 44'h800_0000_0000;
    phase_bases[4] = PPN_W'({$urandom, $urandom});
    phase_bases[5] = BASE_MAX - 1;
    phase_bases[6] = BASE_MAX;
    for (int p = 0; p < 7; p++) begin
      write_base(phase_bases[p]);
      allow_idle = (p != 6);
      for (int i = 0; i < 200; i++) begin
        while (pending_maps.size() >= 4) @(posedge clk);
        pending_maps.push_back(random_map());
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("checked %0d mappings across %0d pool base writes, %0d with offset mismatch",
             checked, base_writes, n_offset);
    $display("outcomes: %0d mapped, %0d pool exhausted, %0d pointer outside pool",
             n_mapped, n_full, n_outside);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
